@@ rtl/tmhq_pkg.sv @@
// Package for the timer min-heap queue: microcode types, control word ROM,
// status codes and shared structs. No dependencies.
package tmhq_pkg;

    localparam int DEFAULT_CAPACITY    = 64;
    localparam int DEFAULT_HANDLE_BITS = 16;
    localparam int KEY_BITS            = 64;
    localparam int HANDLE_FIELD_BITS   = 16;
    localparam int STEP_BITS           = 4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t S_IDLE      = 4'd0;
    localparam step_t S_DISPATCH  = 4'd1;
    localparam step_t S_INS_START = 4'd2;
    localparam step_t S_INS_TOP   = 4'd3;
    localparam step_t S_INS_CMP   = 4'd4;
    localparam step_t S_INS_PLACE = 4'd5;
    localparam step_t S_POP_START = 4'd6;
    localparam step_t S_POP_LOAD  = 4'd7;
    localparam step_t S_POP_TOP   = 4'd8;
    localparam step_t S_POP_CMP   = 4'd9;
    localparam step_t S_POP_PLACE = 4'd10;
    localparam step_t S_EMIT      = 4'd11;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_INS_START = 4'd1,
        OP_INS_READ  = 4'd2,
        OP_INS_MOVE  = 4'd3,
        OP_INS_PLACE = 4'd4,
        OP_POP_START = 4'd5,
        OP_POP_LOAD  = 4'd6,
        OP_POP_READ  = 4'd7,
        OP_POP_MOVE  = 4'd8,
        OP_POP_PLACE = 4'd9,
        OP_EMIT      = 4'd10
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_ACCEPT   = 4'd2,
        C_MODE_POP = 4'd3,
        C_FULL     = 4'd4,
        C_EMPTY    = 4'd5,
        C_POS_ZERO = 4'd6,
        C_KEY_GT   = 4'd7,
        C_NO_CHILD = 4'd8,
        C_LAST_GT  = 4'd9,
        C_OUT_FREE = 4'd10
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  hold;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic mode_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic key_gt;
        logic no_child;
        logic last_gt;
        logic out_free;
    } flags_t;

    typedef struct packed {
        op_t  op;
        logic taken;
        logic idle;
    } ctrl_t;

    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE, hold: 1'b0};
        unique case (step)
            S_IDLE:      w = '{op: OP_NONE,      cond: C_ACCEPT,   target: S_DISPATCH,
                               hold: 1'b1};
            S_DISPATCH:  w = '{op: OP_NONE,      cond: C_MODE_POP, target: S_POP_START,
                               hold: 1'b0};
            S_INS_START: w = '{op: OP_INS_START, cond: C_FULL,     target: S_EMIT,
                               hold: 1'b0};
            S_INS_TOP:   w = '{op: OP_INS_READ,  cond: C_POS_ZERO, target: S_INS_PLACE,
                               hold: 1'b0};
            S_INS_CMP:   w = '{op: OP_INS_MOVE,  cond: C_KEY_GT,   target: S_INS_TOP,
                               hold: 1'b0};
            S_INS_PLACE: w = '{op: OP_INS_PLACE, cond: C_ALWAYS,   target: S_EMIT,
                               hold: 1'b0};
            S_POP_START: w = '{op: OP_POP_START, cond: C_EMPTY,    target: S_EMIT,
                               hold: 1'b0};
            S_POP_LOAD:  w = '{op: OP_POP_LOAD,  cond: C_NEVER,    target: S_IDLE,
                               hold: 1'b0};
            S_POP_TOP:   w = '{op: OP_POP_READ,  cond: C_NO_CHILD, target: S_POP_PLACE,
                               hold: 1'b0};
            S_POP_CMP:   w = '{op: OP_POP_MOVE,  cond: C_LAST_GT,  target: S_POP_TOP,
                               hold: 1'b0};
            S_POP_PLACE: w = '{op: OP_POP_PLACE, cond: C_ALWAYS,   target: S_EMIT,
                               hold: 1'b0};
            S_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_FREE, target: S_IDLE,
                               hold: 1'b1};
            default:     w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE,
                               hold: 1'b0};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/tmhq_mem.sv @@
// Heap entry storage: one write port and two read ports with registered
// read data. Depends on nothing.
module tmhq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 80
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/tmhq_seq.sv @@
// Microcode sequencer: step counter, control word ROM lookup and jump
// condition select. Depends on tmhq_pkg.
module tmhq_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  tmhq_pkg::flags_t flags,
    output tmhq_pkg::ctrl_t  ctrl
);

    tmhq_pkg::step_t  upc_reg;
    tmhq_pkg::step_t  upc_next;
    tmhq_pkg::uword_t uw;
    logic             cond_true;

    assign uw = tmhq_pkg::ucode(upc_reg);

    always_comb
    begin
        unique case (uw.cond)
            tmhq_pkg::C_NEVER:    cond_true = 1'b0;
            tmhq_pkg::C_ALWAYS:   cond_true = 1'b1;
            tmhq_pkg::C_ACCEPT:   cond_true = flags.accept;
            tmhq_pkg::C_MODE_POP: cond_true = flags.mode_pop;
            tmhq_pkg::C_FULL:     cond_true = flags.full;
            tmhq_pkg::C_EMPTY:    cond_true = flags.empty;
            tmhq_pkg::C_POS_ZERO: cond_true = flags.pos_zero;
            tmhq_pkg::C_KEY_GT:   cond_true = flags.key_gt;
            tmhq_pkg::C_NO_CHILD: cond_true = flags.no_child;
            tmhq_pkg::C_LAST_GT:  cond_true = flags.last_gt;
            tmhq_pkg::C_OUT_FREE: cond_true = flags.out_free;
            default:              cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
        begin
            upc_next = uw.target;
        end
        else if (uw.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + tmhq_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tmhq_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op    = uw.op;
    assign ctrl.taken = cond_true;
    assign ctrl.idle  = (upc_reg == tmhq_pkg::S_IDLE);

endmodule

@@ rtl/timer_min_heap_queue_unit.sv @@
// Timer min-heap queue: top level with the heap datapath, stream ports and
// result register. Depends on tmhq_pkg, tmhq_seq and tmhq_mem.
// An insert on a full heap or a pop on an empty one goes straight to the result step;
// otherwise the heap levels are compared in turn (at most log2(CAPACITY) of them), each
// level needing one registered RAM read. One request at a time, accepted at the edge
// after the previous result is registered. Reset clears the sequencer, entry count and
// output valid; the entry RAM is not cleared.
module timer_min_heap_queue_unit #(
    parameter int CAPACITY    = tmhq_pkg::DEFAULT_CAPACITY,
    parameter int HANDLE_BITS = tmhq_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // deadline, task_handle, current_time
    input  logic [0:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // popped_handle, popped_deadline, timer_delay
    output logic [2:0]   m_tuser    // status, timer_update
);

    localparam int KB   = tmhq_pkg::KEY_BITS;
    localparam int HF   = tmhq_pkg::HANDLE_FIELD_BITS;
    localparam int SB   = (HANDLE_BITS < HF) ? HANDLE_BITS : HF;
    localparam int DW   = KB + SB;
    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW = $clog2(CAPACITY + 1);

    tmhq_pkg::flags_t flags;
    tmhq_pkg::ctrl_t  ctrl;

    logic            accept;
    logic            mode_reg;
    logic [KB-1:0]   key_reg;
    logic [SB-1:0]   hnd_reg;
    logic [KB-1:0]   now_reg;
    logic [CNTW-1:0] count_reg;
    logic [IDXW-1:0] pos_reg;
    logic [KB-1:0]   last_dl_reg;
    logic [SB-1:0]   last_hd_reg;
    logic [KB-1:0]   pdl_reg;
    logic [SB-1:0]   phd_reg;
    logic [1:0]      status_reg;
    logic            upd_reg;
    logic [KB-1:0]   root_reg;

    logic            m_tvalid_reg;
    logic [143:0]    m_tdata_reg;
    logic [2:0]      m_tuser_reg;

    logic            we;
    logic [IDXW-1:0] waddr;
    logic [DW-1:0]   wdata;
    logic [IDXW-1:0] raddr_a;
    logic [IDXW-1:0] raddr_b;
    logic [DW-1:0]   rdata_a;
    logic [DW-1:0]   rdata_b;

    logic [IDXW-1:0] par_idx;
    logic [IDXW:0]   c_ext;
    logic [IDXW+1:0] c1_ext;
    logic            right_ok;
    logic            pick_right;
    logic [KB-1:0]   chosen_dl;
    logic [DW-1:0]   chosen_word;
    logic [IDXW-1:0] chosen_idx;
    logic [CNTW-1:0] count_dec;
    logic [KB-1:0]   delay;
    logic            out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = ctrl.idle;
    assign out_free = !m_tvalid_reg || m_tready;

    assign par_idx   = (pos_reg - IDXW'(1)) >> 1;
    assign c_ext     = {pos_reg, 1'b1};
    assign c1_ext    = {1'b0, c_ext} + (IDXW+2)'(1);
    assign count_dec = count_reg - CNTW'(1);

    assign right_ok    = c1_ext < (IDXW+2)'(count_reg);
    assign pick_right  = right_ok && (rdata_b[KB-1:0] < rdata_a[KB-1:0]);
    assign chosen_word = pick_right ? rdata_b : rdata_a;
    assign chosen_dl   = chosen_word[KB-1:0];
    assign chosen_idx  = pick_right ? c1_ext[IDXW-1:0] : c_ext[IDXW-1:0];

    assign delay = (root_reg > now_reg) ? (root_reg - now_reg) : '0;

    assign flags.accept   = accept;
    assign flags.mode_pop = mode_reg;
    assign flags.full     = (count_reg == CNTW'(CAPACITY));
    assign flags.empty    = (count_reg == '0);
    assign flags.pos_zero = (pos_reg == '0);
    assign flags.key_gt   = rdata_a[KB-1:0] > key_reg;
    assign flags.no_child = c_ext >= (IDXW+1)'(count_reg);
    assign flags.last_gt  = last_dl_reg > chosen_dl;
    assign flags.out_free = out_free;

    tmhq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        we      = 1'b0;
        waddr   = pos_reg;
        wdata   = {hnd_reg, key_reg};
        raddr_a = '0;
        raddr_b = '0;
        case (ctrl.op)
            tmhq_pkg::OP_INS_READ:
            begin
                raddr_a = par_idx;
            end
            tmhq_pkg::OP_INS_MOVE:
            begin
                we    = ctrl.taken;
                wdata = rdata_a;
            end
            tmhq_pkg::OP_INS_PLACE:
            begin
                we = 1'b1;
            end
            tmhq_pkg::OP_POP_START:
            begin
                raddr_b = count_dec[IDXW-1:0];
            end
            tmhq_pkg::OP_POP_READ:
            begin
                raddr_a = c_ext[IDXW-1:0];
                raddr_b = c1_ext[IDXW-1:0];
            end
            tmhq_pkg::OP_POP_MOVE:
            begin
                we    = ctrl.taken;
                wdata = chosen_word;
            end
            tmhq_pkg::OP_POP_PLACE:
            begin
                we    = 1'b1;
                wdata = {last_hd_reg, last_dl_reg};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    tmhq_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDXW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == tmhq_pkg::OP_INS_START && !flags.full)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (ctrl.op == tmhq_pkg::OP_POP_START && !flags.empty)
            begin
                count_reg <= count_dec;
            end

            if (ctrl.op == tmhq_pkg::OP_EMIT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tuser[0];
            key_reg    <= s_tdata[KB-1:0];
            hnd_reg    <= s_tdata[KB +: SB];
            now_reg    <= s_tdata[KB+HF +: KB];
            status_reg <= tmhq_pkg::STATUS_OK;
            upd_reg    <= 1'b0;
            pdl_reg    <= '0;
            phd_reg    <= '0;
        end

        if (we && waddr == '0)
        begin
            root_reg <= wdata[KB-1:0];
        end

        case (ctrl.op)
            tmhq_pkg::OP_INS_START:
            begin
                if (flags.full)
                begin
                    status_reg <= tmhq_pkg::STATUS_FULL;
                end
                else
                begin
                    pos_reg <= count_reg[IDXW-1:0];
                end
            end
            tmhq_pkg::OP_INS_MOVE:
            begin
                if (ctrl.taken)
                begin
                    pos_reg <= par_idx;
                end
            end
            tmhq_pkg::OP_INS_PLACE:
            begin
                upd_reg <= 1'b1;
            end
            tmhq_pkg::OP_POP_START:
            begin
                if (flags.empty)
                begin
                    status_reg <= tmhq_pkg::STATUS_EMPTY;
                end
                pos_reg <= '0;
            end
            tmhq_pkg::OP_POP_LOAD:
            begin
                pdl_reg     <= root_reg;
                phd_reg     <= rdata_a[KB +: SB];
                last_dl_reg <= rdata_b[KB-1:0];
                last_hd_reg <= rdata_b[KB +: SB];
            end
            tmhq_pkg::OP_POP_MOVE:
            begin
                if (ctrl.taken)
                begin
                    pos_reg <= chosen_idx;
                end
            end
            tmhq_pkg::OP_POP_PLACE:
            begin
                upd_reg <= (count_reg != '0);
            end
            tmhq_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {(upd_reg ? delay : {KB{1'b0}}), pdl_reg,
                                    HF'(phd_reg)};
                    m_tuser_reg <= {upd_reg, status_reg};
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ tb/timer_min_heap_queue_unit_test.sv @@
// Testbench for timer_min_heap_queue_unit: a directed table and then random
// insert and pop requests, checked against a heap predictor here (typed rows
// against the table). Depends on tmhq_pkg and timer_min_heap_queue_unit RTL.
module timer_min_heap_queue_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = tmhq_pkg::DEFAULT_CAPACITY;
    localparam int HANDLE_KEEP = tmhq_pkg::DEFAULT_HANDLE_BITS;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS_PER_PHASE = 188;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam logic [63:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_handle;
        logic [63:0] popped_deadline;
        logic        timer_update;
        logic [63:0] timer_delay;
    } timer_result_t;

    typedef struct packed {
        logic          mode;
        logic [63:0]   deadline;
        logic [15:0]   task_handle;
        logic [63:0]   current_time;
        int            reps;
        bit            randomized;
        bit            typed;
        timer_result_t want;
    } plan_row_t;

    localparam timer_result_t NO_RESULT    =
        '{tmhq_pkg::STATUS_OK, 16'h0, 64'h0, 1'b0, 64'h0};
    localparam timer_result_t EMPTY_RESULT =
        '{tmhq_pkg::STATUS_EMPTY, 16'h0, 64'h0, 1'b0, 64'h0};
    localparam timer_result_t FULL_RESULT  =
        '{tmhq_pkg::STATUS_FULL, 16'h0, 64'h0, 1'b0, 64'h0};

    localparam int PLAN_ROWS = 20;
    localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 1, 1'b0, 1'b1, EMPTY_RESULT},
        '{MODE_INSERT, KEY_MAX, 16'hFFFF, 64'h0, 1, 1'b0, 1'b1,
          '{tmhq_pkg::STATUS_OK, 16'h0, 64'h0, 1'b1, KEY_MAX}},
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 1, 1'b0, 1'b1,
          '{tmhq_pkg::STATUS_OK, 16'hFFFF, KEY_MAX, 1'b0, 64'h0}},
        '{MODE_INSERT, 64'h0, 16'h0, KEY_MAX, 1, 1'b0, 1'b1,
          '{tmhq_pkg::STATUS_OK, 16'h0, 64'h0, 1'b1, 64'h0}},
        '{MODE_POP, 64'h0, 16'h0, KEY_MAX, 1, 1'b0, 1'b1,
          '{tmhq_pkg::STATUS_OK, 16'h0, 64'h0, 1'b0, 64'h0}},
        '{MODE_INSERT, 64'd1000, 16'h0001, 64'd400, 1, 1'b0, 1'b1,
          '{tmhq_pkg::STATUS_OK, 16'h0, 64'h0, 1'b1, 64'd600}},
        '{MODE_INSERT, 64'd500, 16'h0002, 64'd400, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_INSERT, 64'd500, 16'h0003, 64'd600, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_INSERT, 64'd2000, 16'h0004, 64'h0, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_INSERT, 64'h8000_0000_0000_0000, 16'h8000, 64'h7FFF_FFFF_FFFF_FFFF,
          1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_INSERT, 64'd500, 16'h0005, 64'd499, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_POP, 64'h0, 16'h0, KEY_MAX, 1, 1'b0, 1'b0, NO_RESULT},
        '{MODE_POP, 64'h0, 16'h0, 64'd100, 4, 1'b1, 1'b0, NO_RESULT},
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 1, 1'b0, 1'b1, EMPTY_RESULT},
        '{MODE_INSERT, 64'h0, 16'h0, 64'h0, 64, 1'b1, 1'b0, NO_RESULT},
        '{MODE_INSERT, 64'd7, 16'h00AA, 64'h0, 1, 1'b0, 1'b1, FULL_RESULT},
        '{MODE_INSERT, 64'h0, 16'h5555, KEY_MAX, 1, 1'b0, 1'b1, FULL_RESULT},
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 64, 1'b1, 1'b0, NO_RESULT},
        '{MODE_POP, 64'h0, 16'h0, 64'h0, 1, 1'b0, 1'b1, EMPTY_RESULT}
    };

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;    // deadline, task_handle, current_time
    logic [0:0]   s_tuser = '0;    // mode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;         // popped_handle, popped_deadline, timer_delay
    logic [2:0]   m_tuser;         // status, timer_update

    logic [63:0] heap_keys [HEAP_DEPTH];
    logic [15:0] heap_tasks [HEAP_DEPTH];
    int          heap_size = 0;

    timer_result_t pending_results [$];
    int            mismatches = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            quiet_cycles = 0;

    timer_min_heap_queue_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] delay_to_top(input logic [63:0] now);
        return (heap_keys[0] > now) ? heap_keys[0] - now : 64'h0;
    endfunction

    // Applies one request to the heap copy and returns the result it causes.
    function automatic timer_result_t heap_apply(input logic mode, input logic [63:0] key,
                                                 input logic [15:0] task_handle,
                                                 input logic [63:0] now);
        timer_result_t res;
        logic [63:0]   last_key;
        logic [15:0]   last_task;
        logic [15:0]   kept;
        int            pos;
        int            up;
        int            child;
        res = NO_RESULT;
        kept = 16'(32'(task_handle) & ((32'd1 << HANDLE_KEEP) - 32'd1));
        if (mode == MODE_INSERT)
        begin
            if (heap_size >= HEAP_DEPTH)
            begin
                res.status = tmhq_pkg::STATUS_FULL;
            end
            else
            begin
                pos = heap_size;
                heap_size++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (heap_keys[up] <= key)
                        break;
                    heap_keys[pos] = heap_keys[up];
                    heap_tasks[pos] = heap_tasks[up];
                    pos = up;
                end
                heap_keys[pos] = key;
                heap_tasks[pos] = kept;
                res.timer_update = 1'b1;
                res.timer_delay = delay_to_top(now);
            end
        end
        else if (heap_size == 0)
        begin
            res.status = tmhq_pkg::STATUS_EMPTY;
        end
        else
        begin
            res.popped_deadline = heap_keys[0];
            res.popped_handle = heap_tasks[0];
            heap_size--;
            last_key = heap_keys[heap_size];
            last_task = heap_tasks[heap_size];
            pos = 0;
            while (pos * 2 + 1 < heap_size)
            begin
                child = pos * 2 + 1;
                if (child + 1 < heap_size && heap_keys[child + 1] < heap_keys[child])
                    child++;
                if (last_key <= heap_keys[child])
                    break;
                heap_keys[pos] = heap_keys[child];
                heap_tasks[pos] = heap_tasks[child];
                pos = child;
            end
            heap_keys[pos] = last_key;
            heap_tasks[pos] = last_task;
            if (heap_size > 0)
            begin
                res.timer_update = 1'b1;
                res.timer_delay = delay_to_top(now);
            end
        end
        return res;
    endfunction

    // Deadlines and times are drawn from a few bands so that equal keys, passed
    // deadlines and the ends of the range all come up often.
    function automatic logic [63:0] pick_time_value();
        logic [63:0] value;
        case ($urandom_range(0, 9))
            0: value = 64'h0;
            1: value = KEY_MAX;
            2, 3, 4: value = 64'($urandom_range(0, 31));
            5: value = KEY_MAX - 64'($urandom_range(0, 31));
            default: value = {$urandom, $urandom};
        endcase
        return value;
    endfunction

    task automatic send_request(input logic mode, input logic [63:0] deadline,
                                input logic [15:0] task_handle,
                                input logic [63:0] now, input bit typed,
                                input timer_result_t want);
        timer_result_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {now, task_handle, deadline};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = heap_apply(mode, deadline, task_handle, now);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic compare_field(input string field, input logic [63:0] expected,
                                 input logic [63:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, got %0h", field, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        timer_result_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: tdata %0h tuser %0h",
                       m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                expected = pending_results.pop_front();
                compare_field("status", 64'(expected.status), 64'(m_tuser[1:0]));
                compare_field("timer_update", 64'(expected.timer_update), 64'(m_tuser[2]));
                compare_field("popped_handle", 64'(expected.popped_handle),
                              64'(m_tdata[15:0]));
                compare_field("popped_deadline", expected.popped_deadline, m_tdata[79:16]);
                compare_field("timer_delay", expected.timer_delay, m_tdata[143:80]);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic        mode;
        logic [63:0] deadline;
        logic [15:0] task_handle;
        logic [63:0] now;
        int          insert_pct;
        int          run_left;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < PLAN_ROWS; row++)
        begin
            for (int rep = 0; rep < PLAN[row].reps; rep++)
            begin
                deadline = PLAN[row].deadline;
                task_handle = PLAN[row].task_handle;
                now = PLAN[row].current_time;
                if (PLAN[row].randomized)
                begin
                    deadline = pick_time_value();
                    task_handle = 16'($urandom);
                    now = pick_time_value();
                end
                send_request(PLAN[row].mode, deadline, task_handle, now,
                             PLAN[row].typed, PLAN[row].want);
            end
        end

        // Each phase mixes runs that mostly insert with runs that mostly pop,
        // so the heap swings between empty and full.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 53;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    idle_pct = 21;
                    stall_pct = 21;
                end
            endcase
            run_left = 0;
            insert_pct = 50;
            for (int item = 0; item < RANDOM_ITEMS_PER_PHASE; item++)
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(20, 90);
                    case ($urandom_range(0, 3))
                        0: insert_pct = 95;
                        1: insert_pct = 80;
                        2: insert_pct = 50;
                        default: insert_pct = 15;
                    endcase
                end
                run_left--;
                mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
                send_request(mode, pick_time_value(), 16'($urandom), pick_time_value(),
                             1'b0, NO_RESULT);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tmhq_pkg.sv
rtl/tmhq_mem.sv
rtl/tmhq_seq.sv
rtl/timer_min_heap_queue_unit.sv
tb/timer_min_heap_queue_unit_test.sv
